// File: rtl/core/cmd_pkg.sv
package cmd_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int MAX_RADIUS = 3;

    localparam int CH_W   = 8;
    localparam int PIX_W  = 3 * CH_W;
    localparam int DIM_W  = 12;
    localparam int RAD_W  = 2;
    localparam int IDX_W  = 2;
    localparam int CMP_W  = DIM_W + 1;

    localparam int NUM_SLOTS  = 2 * MAX_RADIUS;
    localparam int NUM_CELLS  = 2 * MAX_RADIUS + 1;
    localparam int SEL_W      = $clog2(NUM_CELLS);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int OROW_W     = $clog2(MAX_HEIGHT);
    localparam int ROW_W      = $clog2(MAX_HEIGHT + 2 * MAX_RADIUS);
    localparam int LAG_W      = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [IDX_W-1:0] REG_MATCH_COLOR  = 2'd0;
    localparam logic [IDX_W-1:0] REG_RADIUS       = 2'd1;
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd2;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd3;

    localparam logic [PIX_W-1:0] RST_MATCH_COLOR  = 24'd0;
    localparam logic [RAD_W-1:0] RST_RADIUS       = 2'd2;
    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 12'd1500;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 12'd1000;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic            is_padding;
    } pix_item_t;

    typedef struct packed {
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_red;
        logic            frame_end;
    } res_item_t;

    typedef struct packed {
        logic             vbit;
        logic [PIX_W-1:0] pix;
    } cell_t;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] color;
        logic [RAD_W-1:0] radius;
    } col_wr_t;

endpackage

// File: rtl/core/cmd_column.sv
module cmd_column (
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [cmd_pkg::COL_W-1:0] rd_addr,
    input  cmd_pkg::col_wr_t      wr,
    output cmd_pkg::cell_t        col_out
);
    import cmd_pkg::*;

    logic [NUM_SLOTS*PIX_W-1:0] line_mem_reg [MAX_WIDTH];
    logic [NUM_SLOTS*PIX_W-1:0] rd_reg;
    logic [NUM_SLOTS*PIX_W-1:0] wr_word;
    logic [PIX_W-1:0]           rows [NUM_SLOTS+1];
    logic [SEL_W-1:0]           span;
    logic                       vbit;

    // rows[0] is the new pixel, rows[j] the pixel j rows above it
    always_comb
    begin
        rows[0] = wr.pix;
        for (int j = 1; j <= NUM_SLOTS; j++)
        begin
            rows[j] = rd_reg[(j-1)*PIX_W +: PIX_W];
        end
        for (int j = 0; j < NUM_SLOTS; j++)
        begin
            wr_word[j*PIX_W +: PIX_W] = rows[j];
        end
        span = SEL_W'({wr.radius, 1'b0});
        vbit = 1'b0;
        for (int j = 0; j <= NUM_SLOTS; j++)
        begin
            if ((SEL_W'(j) <= span) && (rows[j] == wr.color))
            begin
                vbit = 1'b1;
            end
        end
        col_out.vbit = vbit;
        col_out.pix  = rows[SEL_W'(wr.radius)];
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            line_mem_reg[wr.addr] <= wr_word;
        end
        if (rd_en)
        begin
            // one-column rows read back the word still being written
            if (wr.en && (wr.addr == rd_addr))
            begin
                rd_reg <= wr_word;
            end
            else
            begin
                rd_reg <= line_mem_reg[rd_addr];
            end
        end
    end

endmodule

// File: rtl/core/cmd_cell.sv
module cmd_cell (
    input  logic           clk,
    input  logic           shift,
    input  cmd_pkg::cell_t d,
    output cmd_pkg::cell_t q,
    input  logic           in_window,
    input  logic           hit_in,
    output logic           hit_out
);
    import cmd_pkg::*;

    cell_t q_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            q_reg <= d;
        end
    end

    assign q       = q_reg;
    assign hit_out = hit_in | (in_window & q_reg.vbit);

endmodule

// File: rtl/core/color_match_dilation.sv
// Color-match dilation over a raster-order RGB stream, one item per clock sustained
// while the result queue has room. Each interior pixel is replaced by the match color
// when any pixel of the original frame in its (2*radius+1) square equals that color;
// border pixels pass unchanged. Registers are sampled on the first pixel of a frame.
// The result for pixel k comes with the item that carries pixel k + radius*frame_width +
// radius, so padding items must follow the frame to push out its tail; frame_end marks
// the last result, after which the next pixel opens a new frame. A result is registered
// in s1 and s2, then written into the result queue that drives res_valid; the rate is
// set by the line store, one read plus one write per cycle on a 2048 x 144-bit memory
// holding six rows, and by a seven-cell window chain that shifts once per fed item.
// The line store needs no initialization after reset.
module color_match_dilation (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pix_valid,
    output logic                      pix_ready,
    input  cmd_pkg::pix_item_t        pix_data,
    output logic                      res_valid,
    input  logic                      res_ready,
    output cmd_pkg::res_item_t        res_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [cmd_pkg::IDX_W-1:0] cfg_index,
    input  logic [cmd_pkg::PIX_W-1:0] cfg_data
);
    import cmd_pkg::*;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] color;
        logic [RAD_W-1:0] radius;
        logic             emit;
        logic             interior;
        logic             last;
    } s1_t;

    typedef struct packed {
        logic [PIX_W-1:0] color;
        logic [RAD_W-1:0] radius;
        logic             interior;
        logic             last;
    } s2_t;

    logic [PIX_W-1:0] cfg_color_reg;
    logic [RAD_W-1:0] cfg_radius_reg;
    logic [DIM_W-1:0] cfg_width_reg;
    logic [DIM_W-1:0] cfg_height_reg;

    logic [PIX_W-1:0] act_color_reg,  act_color_next;
    logic [RAD_W-1:0] act_radius_reg, act_radius_next;
    logic [DIM_W-1:0] act_width_reg,  act_width_next;
    logic [DIM_W-1:0] act_height_reg, act_height_next;
    logic             started_reg,    started_next;
    logic [ROW_W-1:0] pos_row_reg,    pos_row_next;
    logic [COL_W-1:0] pos_col_reg,    pos_col_next;
    logic [OROW_W-1:0] orow_reg,      orow_next;
    logic [COL_W-1:0] ocol_reg,       ocol_next;
    logic [LAG_W-1:0] lag_reg,        lag_next;

    logic [DIM_W-1:0] clamp_width;
    logic [DIM_W-1:0] clamp_height;
    logic [RAD_W-1:0] clamp_radius;
    logic [LAG_W-1:0] new_lag;
    logic [PIX_W-1:0] cur_color;
    logic [RAD_W-1:0] cur_radius;
    logic [DIM_W-1:0] cur_width;
    logic [DIM_W-1:0] cur_height;
    logic [LAG_W-1:0] cur_lag;
    logic [CMP_W-1:0] orow_x, ocol_x, r_x, w_x, h_x;
    logic             pix_fire;
    logic             in_frame;
    logic             fed;
    logic             emit;
    logic             interior;
    logic             last;
    logic             col_wrap;
    logic             ocol_wrap;

    logic             s1_valid_reg;
    s1_t              s1_reg;
    logic             s2_valid_reg;
    s2_t              s2_reg;

    col_wr_t          col_wr;
    cell_t            col_out;
    cell_t            cell_d   [NUM_CELLS];
    cell_t            cell_q   [NUM_CELLS];
    logic             hit_in   [NUM_CELLS];
    logic             hit_out  [NUM_CELLS];
    logic             win      [NUM_CELLS];
    logic [PIX_W-1:0] res_pix;
    res_item_t        res_item;

    res_item_t              fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]  fifo_cnt_reg;
    logic [FIFO_CNT_W-1:0]  inflight;
    logic                   push;
    logic                   pop;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_color_reg  <= RST_MATCH_COLOR;
            cfg_radius_reg <= RST_RADIUS;
            cfg_width_reg  <= RST_FRAME_WIDTH;
            cfg_height_reg <= RST_FRAME_HEIGHT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MATCH_COLOR:  cfg_color_reg  <= cfg_data;
                REG_RADIUS:       cfg_radius_reg <= cfg_data[RAD_W-1:0];
                REG_FRAME_WIDTH:  cfg_width_reg  <= cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: cfg_height_reg <= cfg_data[DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    // frame position and result scheduling
    always_comb
    begin
        clamp_width = cfg_width_reg;
        if (cfg_width_reg == '0)
        begin
            clamp_width = DIM_W'(1);
        end
        else if (cfg_width_reg > DIM_W'(MAX_WIDTH))
        begin
            clamp_width = DIM_W'(MAX_WIDTH);
        end
        clamp_height = cfg_height_reg;
        if (cfg_height_reg == '0)
        begin
            clamp_height = DIM_W'(1);
        end
        else if (cfg_height_reg > DIM_W'(MAX_HEIGHT))
        begin
            clamp_height = DIM_W'(MAX_HEIGHT);
        end
        clamp_radius = (cfg_radius_reg > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                              : cfg_radius_reg;
        new_lag = LAG_W'(clamp_radius) * LAG_W'(clamp_width) + LAG_W'(clamp_radius);

        cur_color  = started_reg ? act_color_reg  : cfg_color_reg;
        cur_radius = started_reg ? act_radius_reg : clamp_radius;
        cur_width  = started_reg ? act_width_reg  : clamp_width;
        cur_height = started_reg ? act_height_reg : clamp_height;
        cur_lag    = started_reg ? lag_reg        : new_lag;

        orow_x = CMP_W'(orow_reg);
        ocol_x = CMP_W'(ocol_reg);
        r_x    = CMP_W'(cur_radius);
        w_x    = CMP_W'(cur_width);
        h_x    = CMP_W'(cur_height);

        pix_fire  = pix_valid && pix_ready;
        in_frame  = CMP_W'(pos_row_reg) < h_x;
        fed       = pix_fire && (!in_frame || !pix_data.is_padding);
        emit      = fed && (cur_lag == '0);
        interior  = (orow_x >= r_x) && ((orow_x + r_x) < h_x) &&
                    (ocol_x >= r_x) && ((ocol_x + r_x) < w_x);
        last      = (orow_x == (h_x - CMP_W'(1))) && (ocol_x == (w_x - CMP_W'(1)));
        col_wrap  = (CMP_W'(pos_col_reg) + CMP_W'(1)) == w_x;
        ocol_wrap = (ocol_x + CMP_W'(1)) == w_x;

        act_color_next  = act_color_reg;
        act_radius_next = act_radius_reg;
        act_width_next  = act_width_reg;
        act_height_next = act_height_reg;
        started_next    = started_reg;
        pos_row_next    = pos_row_reg;
        pos_col_next    = pos_col_reg;
        orow_next       = orow_reg;
        ocol_next       = ocol_reg;
        lag_next        = lag_reg;

        if (fed)
        begin
            started_next    = 1'b1;
            act_color_next  = cur_color;
            act_radius_next = cur_radius;
            act_width_next  = cur_width;
            act_height_next = cur_height;
            lag_next        = (cur_lag == '0) ? '0 : cur_lag - LAG_W'(1);
            if (col_wrap)
            begin
                pos_col_next = '0;
                pos_row_next = pos_row_reg + ROW_W'(1);
            end
            else
            begin
                pos_col_next = pos_col_reg + COL_W'(1);
            end
            if (emit)
            begin
                if (ocol_wrap)
                begin
                    ocol_next = '0;
                    orow_next = orow_reg + OROW_W'(1);
                end
                else
                begin
                    ocol_next = ocol_reg + COL_W'(1);
                end
                if (last)
                begin
                    started_next = 1'b0;
                    pos_row_next = '0;
                    pos_col_next = '0;
                    orow_next    = '0;
                    ocol_next    = '0;
                    lag_next     = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_color_reg  <= RST_MATCH_COLOR;
            act_radius_reg <= RST_RADIUS;
            act_width_reg  <= RST_FRAME_WIDTH;
            act_height_reg <= RST_FRAME_HEIGHT;
            started_reg    <= 1'b0;
            pos_row_reg    <= '0;
            pos_col_reg    <= '0;
            orow_reg       <= '0;
            ocol_reg       <= '0;
            lag_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
        end
        else
        begin
            act_color_reg  <= act_color_next;
            act_radius_reg <= act_radius_next;
            act_width_reg  <= act_width_next;
            act_height_reg <= act_height_next;
            started_reg    <= started_next;
            pos_row_reg    <= pos_row_next;
            pos_col_reg    <= pos_col_next;
            orow_reg       <= orow_next;
            ocol_reg       <= ocol_next;
            lag_reg        <= lag_next;
            s1_valid_reg   <= fed;
            s2_valid_reg   <= s1_valid_reg && s1_reg.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fed)
        begin
            s1_reg.col      <= pos_col_reg;
            s1_reg.pix      <= {pix_data.red, pix_data.green, pix_data.blue};
            s1_reg.color    <= cur_color;
            s1_reg.radius   <= cur_radius;
            s1_reg.emit     <= emit;
            s1_reg.interior <= interior;
            s1_reg.last     <= last;
        end
        if (s1_valid_reg)
        begin
            s2_reg.color    <= s1_reg.color;
            s2_reg.radius   <= s1_reg.radius;
            s2_reg.interior <= s1_reg.interior;
            s2_reg.last     <= s1_reg.last;
        end
    end

    // line store and vertical match
    always_comb
    begin
        col_wr.en     = s1_valid_reg;
        col_wr.addr   = s1_reg.col;
        col_wr.pix    = s1_reg.pix;
        col_wr.color  = s1_reg.color;
        col_wr.radius = s1_reg.radius;
    end

    cmd_column u_column (
        .clk     (clk),
        .rd_en   (fed),
        .rd_addr (pos_col_reg),
        .wr      (col_wr),
        .col_out (col_out)
    );

    // horizontal window chain, cell 0 is the newest column
    always_comb
    begin
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            cell_d[i] = (i == 0) ? col_out : cell_q[(i == 0) ? 0 : i - 1];
            hit_in[i] = (i == 0) ? 1'b0 : hit_out[(i == 0) ? 0 : i - 1];
            win[i]    = SEL_W'(i) <= SEL_W'({s2_reg.radius, 1'b0});
        end
    end

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        cmd_cell u_cell (
            .clk       (clk),
            .shift     (s1_valid_reg),
            .d         (cell_d[i]),
            .q         (cell_q[i]),
            .in_window (win[i]),
            .hit_in    (hit_in[i]),
            .hit_out   (hit_out[i])
        );
    end

    always_comb
    begin
        res_pix = cell_q[SEL_W'(s2_reg.radius)].pix;
        if (s2_reg.interior && hit_out[NUM_CELLS-1])
        begin
            res_pix = s2_reg.color;
        end
        res_item.out_blue  = res_pix[CH_W-1:0];
        res_item.out_green = res_pix[2*CH_W-1:CH_W];
        res_item.out_red   = res_pix[3*CH_W-1:2*CH_W];
        res_item.frame_end = s2_reg.last;
    end

    // result queue, input credit covers items still in the pipeline
    assign push      = s2_valid_reg;
    assign pop       = res_valid && res_ready;
    assign res_valid = fifo_cnt_reg != '0;
    assign res_data  = fifo_reg[rd_ptr_reg];
    assign inflight  = fifo_cnt_reg + FIFO_CNT_W'(s1_valid_reg) + FIFO_CNT_W'(s2_valid_reg);
    assign pix_ready = inflight < FIFO_CNT_W'(FIFO_DEPTH);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= res_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            if (push && !pop)
            begin
                fifo_cnt_reg <= fifo_cnt_reg + FIFO_CNT_W'(1);
            end
            else if (pop && !push)
            begin
                fifo_cnt_reg <= fifo_cnt_reg - FIFO_CNT_W'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        inflight <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overcommitted");

    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        (fed && (cur_lag != '0)) |=> !(s1_valid_reg && s1_reg.emit))
        else $error("result scheduled before window filled");

    a_frame_close: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && last) |=> (!started_reg && (pos_row_reg == '0) && (orow_reg == '0)))
        else $error("frame state not cleared after last result");
`endif

endmodule

// File: test/color_match_dilation_checker.sv
`timescale 1ns / 100ps

module color_match_dilation_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pix_valid,
    input  logic                      pix_ready,
    input  cmd_pkg::pix_item_t        pix_data,
    input  logic                      res_valid,
    input  logic                      res_ready,
    input  cmd_pkg::res_item_t        res_data,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [cmd_pkg::IDX_W-1:0] cfg_index,
    input  logic [cmd_pkg::PIX_W-1:0] cfg_data,
    output int                        mismatches,
    output int                        pending_pixels
);

    import cmd_pkg::*;

    localparam int RING_ROWS = 2 * MAX_RADIUS + 1;

    logic [PIX_W-1:0] row_ring [RING_ROWS][MAX_WIDTH];

    // position of the next pixel and of the next result pixel
    int unsigned      row_in;
    int unsigned      col_in;
    int unsigned      res_idx;
    int unsigned      flush_seen;
    bit               frame_open;

    // register shadows and the copy latched on the first pixel of a frame
    logic [PIX_W-1:0] reg_color;
    logic [RAD_W-1:0] reg_radius;
    logic [DIM_W-1:0] reg_width;
    logic [DIM_W-1:0] reg_height;
    logic [PIX_W-1:0] act_color;
    int unsigned      act_radius;
    int unsigned      act_width;
    int unsigned      act_height;

    res_item_t        expected_pixels [$];
    res_item_t        want;

    function automatic int unsigned fit_dim(logic [DIM_W-1:0] v, int unsigned limit);
        if (v == '0)
        begin
            return 1;
        end
        return (v > limit) ? limit : int'(v);
    endfunction

    function automatic void dilate_step(pix_item_t it);
        int unsigned      total;
        int unsigned      lag;
        int unsigned      fed;
        int unsigned      orow;
        int unsigned      ocol;
        logic [PIX_W-1:0] pix;
        res_item_t        res;
        bit               hit;
        if (!frame_open)
        begin
            if (it.is_padding)
            begin
                return;
            end
            act_color  = reg_color;
            act_radius = reg_radius;
            act_width  = fit_dim(reg_width, MAX_WIDTH);
            act_height = fit_dim(reg_height, MAX_HEIGHT);
            frame_open = 1'b1;
        end
        if (row_in < act_height)
        begin
            if (it.is_padding)
            begin
                return;
            end
            row_ring[row_in % RING_ROWS][col_in] = {it.red, it.green, it.blue};
            col_in++;
            if (col_in >= act_width)
            begin
                col_in = 0;
                row_in++;
            end
        end
        else
        begin
            flush_seen++;
        end
        total = act_width * act_height;
        lag   = act_radius * act_width + act_radius;
        fed   = row_in * act_width + col_in + flush_seen;
        if (res_idx >= total || fed < res_idx + lag + 1)
        begin
            return;
        end
        orow = res_idx / act_width;
        ocol = res_idx % act_width;
        pix  = row_ring[orow % RING_ROWS][ocol];
        hit  = 1'b0;
        if (orow >= act_radius && orow + act_radius < act_height &&
            ocol >= act_radius && ocol + act_radius < act_width)
        begin
            for (int unsigned y = orow - act_radius; y <= orow + act_radius; y++)
            begin
                for (int unsigned x = ocol - act_radius; x <= ocol + act_radius; x++)
                begin
                    if (row_ring[y % RING_ROWS][x] == act_color)
                    begin
                        hit = 1'b1;
                    end
                end
            end
        end
        if (hit)
        begin
            pix = act_color;
        end
        res_idx++;
        res.out_blue  = pix[CH_W-1:0];
        res.out_green = pix[2*CH_W-1:CH_W];
        res.out_red   = pix[PIX_W-1:2*CH_W];
        res.frame_end = (res_idx == total);
        expected_pixels.insert(expected_pixels.size(), res);
        if (res.frame_end)
        begin
            row_in     = 0;
            col_in     = 0;
            res_idx    = 0;
            flush_seen = 0;
            frame_open = 1'b0;
        end
    endfunction

    function automatic void check_field(string name, logic [CH_W-1:0] exp_v,
                                        logic [CH_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_in         = 0;
            col_in         = 0;
            res_idx        = 0;
            flush_seen     = 0;
            frame_open     = 1'b0;
            reg_color      = RST_MATCH_COLOR;
            reg_radius     = RST_RADIUS;
            reg_width      = RST_FRAME_WIDTH;
            reg_height     = RST_FRAME_HEIGHT;
            act_color      = RST_MATCH_COLOR;
            act_radius     = RST_RADIUS;
            act_width      = RST_FRAME_WIDTH;
            act_height     = RST_FRAME_HEIGHT;
            mismatches     = 0;
            expected_pixels.delete();
            pending_pixels <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result item, expected none actual %h",
                             $time, res_data);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("out_blue", want.out_blue, res_data.out_blue);
                    check_field("out_green", want.out_green, res_data.out_green);
                    check_field("out_red", want.out_red, res_data.out_red);
                    check_field("frame_end", CH_W'(want.frame_end),
                                CH_W'(res_data.frame_end));
                end
            end
            if (pix_valid && pix_ready)
            begin
                dilate_step(pix_data);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MATCH_COLOR:  reg_color  = cfg_data;
                    REG_RADIUS:       reg_radius = cfg_data[RAD_W-1:0];
                    REG_FRAME_WIDTH:  reg_width  = cfg_data[DIM_W-1:0];
                    REG_FRAME_HEIGHT: reg_height = cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
            pending_pixels <= expected_pixels.size();
        end
    end

endmodule

// File: test/color_match_dilation_tb.sv
`timescale 1ns / 100ps

module color_match_dilation_tb;

    import cmd_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               pix_valid = 1'b0;
    logic               pix_ready;
    pix_item_t          pix_data = '0;
    logic               res_valid;
    logic               res_ready = 1'b0;
    res_item_t          res_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [PIX_W-1:0]   cfg_data = '0;

    int                 mismatches;
    int                 pending_pixels;

    int                 tx_idle_pct = 0;
    int                 rx_idle_pct = 0;
    int unsigned        sent_items = 0;

    // frame geometry as the block will see it
    int unsigned        frame_w;
    int unsigned        frame_h;
    int unsigned        frame_r;
    logic [PIX_W-1:0]   frame_color;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    color_match_dilation i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    color_match_dilation_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .pix_valid      (pix_valid),
        .pix_ready      (pix_ready),
        .pix_data       (pix_data),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res_data       (res_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .pending_pixels (pending_pixels)
    );

    always @(posedge clk)
    begin
        res_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic pix_item_t make_item(logic [PIX_W-1:0] color, bit pad);
        pix_item_t it;
        it.blue       = color[CH_W-1:0];
        it.green      = color[2*CH_W-1:CH_W];
        it.red        = color[PIX_W-1:2*CH_W];
        it.is_padding = pad;
        return it;
    endfunction

    function automatic logic [PIX_W-1:0] pick_color(int hit_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < hit_pct)
        begin
            return frame_color;
        end
        // one bit off the match color in any channel
        if (roll < hit_pct + 6)
        begin
            return frame_color ^ (24'h1 << $urandom_range(PIX_W - 1));
        end
        if (roll < hit_pct + 9)
        begin
            return 24'h000000;
        end
        if (roll < hit_pct + 12)
        begin
            return 24'hFFFFFF;
        end
        return PIX_W'($urandom);
    endfunction

    task automatic send_item(pix_item_t it);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= it;
        @(posedge clk);
        while (!pix_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [PIX_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
    endtask

    // unused upper data bits carry junk, the block keeps only the field width
    task automatic configure(logic [PIX_W-1:0] color, int unsigned r, int unsigned w,
                             int unsigned h);
        logic [PIX_W-1:0] junk;
        junk = PIX_W'($urandom);
        write_reg(REG_MATCH_COLOR, color);
        write_reg(REG_RADIUS, {junk[PIX_W-1:RAD_W], r[RAD_W-1:0]});
        junk = PIX_W'($urandom);
        write_reg(REG_FRAME_WIDTH, {junk[PIX_W-1:DIM_W], w[DIM_W-1:0]});
        junk = PIX_W'($urandom);
        write_reg(REG_FRAME_HEIGHT, {junk[PIX_W-1:DIM_W], h[DIM_W-1:0]});
        frame_color = color;
        frame_r     = r;
        frame_w     = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
        frame_h     = (h == 0) ? 1 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
    endtask

    task automatic send_frame(int hit_pct);
        int unsigned lag;
        // padding before the first pixel is ignored
        repeat ($urandom_range(2)) send_item(make_item(PIX_W'($urandom), 1'b1));
        for (int unsigned i = 0; i < frame_w * frame_h; i++)
        begin
            if ($urandom_range(99) < 3)
            begin
                send_item(make_item(PIX_W'($urandom), 1'b1));
            end
            send_item(make_item(pick_color(hit_pct), 1'b0));
        end
        // tail flush, a pixel past the frame counts as a flush item
        lag = frame_r * frame_w + frame_r;
        for (int unsigned i = 0; i < lag; i++)
        begin
            send_item(make_item(PIX_W'($urandom), $urandom_range(99) < 80));
        end
        sent_items += frame_w * frame_h + lag;
        drain();
    endtask

    task automatic random_frame();
        int unsigned      w;
        int unsigned      h;
        int               roll;
        logic [PIX_W-1:0] color;
        roll = $urandom_range(99);
        w = (roll < 10) ? $urandom_range(1, 64) : $urandom_range(1, 20);
        h = (roll > 90) ? $urandom_range(1, 24) : $urandom_range(1, 10);
        if ($urandom_range(49) == 0)
        begin
            w = 0;
        end
        if ($urandom_range(49) == 0)
        begin
            h = 0;
        end
        roll = $urandom_range(9);
        color = (roll == 0) ? 24'h000000 : ((roll == 1) ? 24'hFFFFFF : 24'($urandom));
        configure(color, $urandom_range(3), w, h);
        send_frame($urandom_range(8));
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 27;
        rx_idle_pct = 85;

        // reset radius and match color, small frame
        write_reg(REG_FRAME_WIDTH, 24'd5);
        write_reg(REG_FRAME_HEIGHT, 24'd5);
        frame_w     = 5;
        frame_h     = 5;
        frame_r     = RST_RADIUS;
        frame_color = RST_MATCH_COLOR;
        send_frame(10);

        // zero sizes, largest radius
        configure(24'hFFFFFF, 3, 0, 0);
        send_frame(50);
        configure(24'h000000, 0, 3, 2);
        send_frame(30);
        // a single interior pixel
        configure(PIX_W'($urandom), 3, 7, 7);
        send_frame(2);

        while (sent_items < 400)
        begin
            random_frame();
        end

        tx_idle_pct = 85;
        rx_idle_pct = 27;
        while (sent_items < 800)
        begin
            random_frame();
        end

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        while (sent_items < 1150)
        begin
            random_frame();
        end

        // a wider row
        configure(PIX_W'($urandom), 1, 100, 2);
        send_frame(5);

        if (mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
